[rtl/core/cau_pkg.sv]
// Shared types, constants and helpers for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int RES_W         = 16;
    localparam int RES_MAX       = 32767;
    localparam int RES_MIN_MAG   = 32768;

    // quotient bits resolved by the divider; larger quotients are flagged as overflow
    localparam int QUOT_W     = 17;
    localparam int DIV_LAT    = QUOT_W + 2;
    localparam int ROOT_W     = 16;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQRT_LAT   = SQRT_STEPS + 1;

    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_CONJ = 3'd4,
        MODE_MAG  = 3'd5
    } t_mode;

    typedef struct packed {
        logic signed [RES_W-1:0] val;
        logic                    sat;
    } t_clamp;

    typedef struct packed {
        logic signed [RES_W-1:0] re;
        logic signed [RES_W-1:0] im;
        logic                    dz;
        logic                    sat;
    } t_res;

    function automatic t_clamp clamp16(input logic signed [33:0] v);
        t_clamp c;
        if (v > 34'sd32767) begin
            c.val = 16'sh7fff;
            c.sat = 1'b1;
        end else if (v < -34'sd32768) begin
            c.val = 16'sh8000;
            c.sat = 1'b1;
        end else begin
            c.val = v[15:0];
            c.sat = 1'b0;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/cau_div.sv]
// Pipelined restoring divider: floor(num * 2^F / den) with sign, clamped to 16 bits.
`default_nettype none

module cau_div #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [31:0]         i_num,
    input  logic                i_neg,
    input  logic [31:0]         i_den,
    output cau_pkg::t_clamp     o_quot
);

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int QW    = cau_pkg::QUOT_W;

    typedef struct packed {
        logic [32:0]   rem;
        logic [QW-1:0] low;
        logic [QW-1:0] quot;
        logic [31:0]   den;
        logic          ovf;
        logic          neg;
    } t_step;

    t_step r_st [QW+1];
    t_step n_st [QW+1];
    cau_pkg::t_clamp r_quot;
    cau_pkg::t_clamp n_quot;

    logic [NUM_W-1:0] num_sh;
    logic [NUM_W-1:0] num_hi;
    logic [32:0]      shifted;
    logic [QW:0]      mag;

    assign num_sh = NUM_W'(i_num) << FRAC_BITS;
    assign num_hi = num_sh >> QW;

    always_comb begin
        // init: quotient fits in QW bits only if the high part is below den
        n_st[0].ovf  = num_hi >= NUM_W'(i_den);
        n_st[0].rem  = 33'(num_hi);
        n_st[0].low  = num_sh[QW-1:0];
        n_st[0].quot = '0;
        n_st[0].den  = i_den;
        n_st[0].neg  = i_neg;
        shifted      = '0;
        for (int k = 1; k <= QW; k++) begin
            n_st[k] = r_st[k-1];
            shifted = {r_st[k-1].rem[31:0], r_st[k-1].low[QW-1]};
            n_st[k].low = r_st[k-1].low << 1;
            if (shifted >= {1'b0, r_st[k-1].den}) begin
                n_st[k].rem  = shifted - {1'b0, r_st[k-1].den};
                n_st[k].quot = {r_st[k-1].quot[QW-2:0], 1'b1};
            end else begin
                n_st[k].rem  = shifted;
                n_st[k].quot = {r_st[k-1].quot[QW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        // negative quotients round toward minus infinity
        mag = {1'b0, r_st[QW].quot} + {{QW{1'b0}}, |r_st[QW].rem};
        if (r_st[QW].neg) begin
            n_quot.sat = r_st[QW].ovf || (mag > (QW+1)'(cau_pkg::RES_MIN_MAG));
            n_quot.val = n_quot.sat ? 16'sh8000 : 16'(~mag + 1'b1);
        end else begin
            n_quot.sat = r_st[QW].ovf || (r_st[QW].quot > QW'(cau_pkg::RES_MAX));
            n_quot.val = n_quot.sat ? 16'sh7fff : r_st[QW].quot[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= QW; k++) begin
                r_st[k] <= n_st[k];
            end
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

[rtl/core/cau_sqrt.sv]
// Pipelined integer square root, one root bit per stage, clamped to 16 bits signed.
`default_nettype none

module cau_sqrt (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [31:0]     i_val,
    output cau_pkg::t_clamp o_root
);

    localparam int SQ = cau_pkg::SQRT_STEPS;
    localparam int RW = cau_pkg::ROOT_W;

    typedef struct packed {
        logic [RW+1:0] rem;
        logic [RW-1:0] root;
        logic [31:0]   bits;
    } t_step;

    t_step r_st [SQ];
    t_step n_st [SQ];
    t_step src;
    cau_pkg::t_clamp r_root;

    logic [RW+3:0] cur;
    logic [RW+3:0] trial;

    always_comb begin
        src   = '0;
        cur   = '0;
        trial = '0;
        for (int k = 0; k < SQ; k++) begin
            if (k == 0) begin
                src      = '0;
                src.bits = i_val;
            end else begin
                src = r_st[k-1];
            end
            cur   = {src.rem, src.bits[31:30]};
            trial = {2'b00, src.root, 2'b01};
            n_st[k].bits = src.bits << 2;
            if (cur >= trial) begin
                n_st[k].rem  = (RW+2)'(cur - trial);
                n_st[k].root = {src.root[RW-2:0], 1'b1};
            end else begin
                n_st[k].rem  = cur[RW+1:0];
                n_st[k].root = {src.root[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ; k++) begin
                r_st[k] <= n_st[k];
            end
            r_root.sat <= r_st[SQ-1].root[RW-1];
            r_root.val <= r_st[SQ-1].root[RW-1] ? 16'sh7fff : r_st[SQ-1].root;
        end
    end

    assign o_root = r_root;

endmodule

`default_nettype wire

[rtl/core/complex_arithmetic_unit.sv]
// Complex arithmetic unit top level: pipelined add/sub/mul/div/conj/magnitude on Q8.8 operands.
//
// One transaction in, one transaction out, in order. A new transaction is taken every cycle while
// o_stall is low, for a sustained rate of one transaction per cycle while i_stall is low. From
// acceptance to o_valid it passes the products, the sums, a 19-stage divider lane of which 17 stages
// resolve one quotient bit each, and the output register. The 16-stage square root runs beside the
// divider and lines up with it. Output is an output register plus a one-entry skid buffer, so
// o_stall is a register and the pipeline freezes only once the skid entry is holding a result.
// Rounding is toward minus infinity; every result part is clamped to 16 bits signed and o_saturated
// reports it. Divide by zero returns zeros with o_div_zero set. Unused mode codes return zeros.
`default_nettype none

module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_mode,
    input  logic signed [15:0] i_a_re,
    input  logic signed [15:0] i_a_im,
    input  logic signed [15:0] i_b_re,
    input  logic signed [15:0] i_b_im,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_res_re,
    output logic signed [15:0] o_res_im,
    output logic               o_div_zero,
    output logic               o_saturated
);

    localparam int DL       = cau_pkg::DIV_LAT;
    // sqrt is shorter than the divider: feed it from a later sideband tap
    localparam int SQRT_TAP = cau_pkg::DIV_LAT - cau_pkg::SQRT_LAT - 1;

    typedef struct packed {
        cau_pkg::t_mode     mode;
        cau_pkg::t_res      early;
        logic signed [31:0] p_rr;
        logic signed [31:0] p_ii;
        logic signed [31:0] p_ir;
        logic signed [31:0] p_ri;
        logic signed [31:0] p_ar2;
        logic signed [31:0] p_ai2;
        logic signed [31:0] p_br2;
        logic signed [31:0] p_bi2;
    } t_s1;

    typedef struct packed {
        cau_pkg::t_mode mode;
        cau_pkg::t_res  early;
        logic [31:0]    num_re;
        logic           neg_re;
        logic [31:0]    num_im;
        logic           neg_im;
        logic [31:0]    den;
        logic [31:0]    sq;
    } t_s2;

    typedef struct packed {
        cau_pkg::t_mode mode;
        cau_pkg::t_res  early;
        logic [31:0]    sq;
    } t_side;

    logic          r_out_v, r_skid_v;

    // stall only from the skid register; whole pipe advances together
    logic en;
    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    logic r_s1_v;
    logic r_s2_v;
    logic r_sb_v [DL];
    t_s1   r_s1, n_s1;
    t_s2   r_s2, n_s2;
    t_side r_sb [DL];

    cau_pkg::t_res r_out, r_skid, tail;
    logic          tail_fire;

    cau_pkg::t_clamp c_re, c_im, m_re, m_im;
    cau_pkg::t_clamp q_re, q_im, root;
    logic signed [33:0] mul_re, mul_im, dn_re, dn_im, mag_re, mag_im;

    // stage 1: products, and the results that need no product
    always_comb begin
        n_s1.mode  = cau_pkg::t_mode'(i_mode);
        n_s1.p_rr  = i_a_re * i_b_re;
        n_s1.p_ii  = i_a_im * i_b_im;
        n_s1.p_ir  = i_a_im * i_b_re;
        n_s1.p_ri  = i_a_re * i_b_im;
        n_s1.p_ar2 = i_a_re * i_a_re;
        n_s1.p_ai2 = i_a_im * i_a_im;
        n_s1.p_br2 = i_b_re * i_b_re;
        n_s1.p_bi2 = i_b_im * i_b_im;
        c_re = '0;
        c_im = '0;
        unique case (n_s1.mode) inside
            cau_pkg::MODE_ADD: begin
                c_re = cau_pkg::clamp16(34'(i_a_re) + 34'(i_b_re));
                c_im = cau_pkg::clamp16(34'(i_a_im) + 34'(i_b_im));
            end
            cau_pkg::MODE_SUB: begin
                c_re = cau_pkg::clamp16(34'(i_a_re) - 34'(i_b_re));
                c_im = cau_pkg::clamp16(34'(i_a_im) - 34'(i_b_im));
            end
            cau_pkg::MODE_CONJ: begin
                c_re = cau_pkg::clamp16(34'(i_a_re));
                c_im = cau_pkg::clamp16(34'sd0 - 34'(i_a_im));
            end
            default: begin
                c_re = '0;
                c_im = '0;
            end
        endcase
        n_s1.early.re  = c_re.val;
        n_s1.early.im  = c_im.val;
        n_s1.early.sat = c_re.sat | c_im.sat;
        n_s1.early.dz  = 1'b0;
    end

    // stage 2: sums, multiply result, divider and sqrt operands
    always_comb begin
        mul_re = (34'(r_s1.p_rr) - 34'(r_s1.p_ii)) >>> FRAC_BITS;
        mul_im = (34'(r_s1.p_ir) + 34'(r_s1.p_ri)) >>> FRAC_BITS;
        m_re   = cau_pkg::clamp16(mul_re);
        m_im   = cau_pkg::clamp16(mul_im);
        dn_re  = 34'(r_s1.p_rr) + 34'(r_s1.p_ii);
        dn_im  = 34'(r_s1.p_ir) - 34'(r_s1.p_ri);
        mag_re = dn_re[33] ? -dn_re : dn_re;
        mag_im = dn_im[33] ? -dn_im : dn_im;

        n_s2.mode   = r_s1.mode;
        n_s2.num_re = mag_re[31:0];
        n_s2.neg_re = dn_re[33];
        n_s2.num_im = mag_im[31:0];
        n_s2.neg_im = dn_im[33];
        n_s2.den    = r_s1.p_br2[31:0] + r_s1.p_bi2[31:0];
        n_s2.sq     = r_s1.p_ar2[31:0] + r_s1.p_ai2[31:0];
        n_s2.early  = '0;
        unique case (r_s1.mode) inside
            cau_pkg::MODE_MUL: begin
                n_s2.early.re  = m_re.val;
                n_s2.early.im  = m_im.val;
                n_s2.early.sat = m_re.sat | m_im.sat;
            end
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_CONJ: begin
                n_s2.early = r_s1.early;
            end
            default: begin
                n_s2.early = '0;
            end
        endcase
        n_s2.early.dz = (r_s1.mode == cau_pkg::MODE_DIV) && (n_s2.den == 32'd0);
    end

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s2.num_re),
        .i_neg (r_s2.neg_re),
        .i_den (r_s2.den),
        .o_quot(q_re)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s2.num_im),
        .i_neg (r_s2.neg_im),
        .i_den (r_s2.den),
        .o_quot(q_im)
    );

    cau_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_val (r_sb[SQRT_TAP].sq),
        .o_root(root)
    );

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_sb[0].mode  <= r_s2.mode;
            r_sb[0].early <= r_s2.early;
            r_sb[0].sq    <= r_s2.sq;
            for (int k = 1; k < DL; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // valid bits travel with the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            for (int k = 0; k < DL; k++) begin
                r_sb_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_s1_v    <= i_valid;
            r_s2_v    <= r_s1_v;
            r_sb_v[0] <= r_s2_v;
            for (int k = 1; k < DL; k++) begin
                r_sb_v[k] <= r_sb_v[k-1];
            end
        end
    end

    // final select: divider and root land together with the sideband tail
    always_comb begin
        tail = r_sb[DL-1].early;
        unique case (r_sb[DL-1].mode) inside
            cau_pkg::MODE_DIV: begin
                if (r_sb[DL-1].early.dz) begin
                    tail = '0;
                    tail.dz = 1'b1;
                end else begin
                    tail.re  = q_re.val;
                    tail.im  = q_im.val;
                    tail.sat = q_re.sat | q_im.sat;
                    tail.dz  = 1'b0;
                end
            end
            cau_pkg::MODE_MAG: begin
                tail.re  = root.val;
                tail.im  = '0;
                tail.sat = root.sat;
                tail.dz  = 1'b0;
            end
            default: begin
                tail = r_sb[DL-1].early;
            end
        endcase
    end

    assign tail_fire = r_sb_v[DL-1] && en;

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= tail_fire;
            end
        end else if (tail_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : tail;
        end else if (tail_fire) begin
            r_skid <= tail;
        end
    end

    assign o_valid     = r_out_v;
    assign o_res_re    = r_out.re;
    assign o_res_im    = r_out.im;
    assign o_div_zero  = r_out.dz;
    assign o_saturated = r_out.sat;

    // skid entry only fills behind a stalled output transaction
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid filled without a stalled output");

    // a held skid entry implies the output register is occupied
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds data with empty output register");

    // divide by zero returns clean zeros
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_zero) |-> (o_res_re == 16'sd0 && o_res_im == 16'sd0 && !o_saturated))
        else $error("divide by zero result not zero");

endmodule

`default_nettype wire

[dv/tb_complex_arithmetic_unit.sv]
// Self-checking testbench for the complex arithmetic unit: random and directed operands, all modes.
`default_nettype none

module tb_complex_arithmetic_unit;

    localparam int LATENCY   = 22;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1950;

    // one operation request
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } t_op;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_mode;
    logic signed [15:0] i_a_re, i_a_im, i_b_re, i_b_im;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_res_re, o_res_im;
    logic               o_div_zero, o_saturated;

    complex_arithmetic_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_a_re(i_a_re), .i_a_im(i_a_im), .i_b_re(i_b_re),
        .i_b_im(i_b_im), .o_valid(o_valid), .i_stall(i_stall), .o_res_re(o_res_re),
        .o_res_im(o_res_im), .o_div_zero(o_div_zero), .o_saturated(o_saturated)
    );

    t_op           pending_ops[$];   // operations waiting to be sent
    cau_pkg::t_res expected_res[$];  // predicted results, oldest first
    int   n_errors   = 0;
    int   n_checked  = 0;
    int   mode_seen[8];
    bit   hold_send  = 1'b0; // pressure: sender waits for the pipe to drain
    int   idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic logic signed [63:0] floor_q(input logic signed [63:0] n,
                                                   input logic signed [63:0] d);
        logic signed [63:0] q;
        q = n / d;                      // truncates toward zero
        if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
        return q;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v, inout logic sat);
        if (v > 64'sd32767) begin
            sat = 1'b1;
            return 16'sh7fff;
        end
        if (v < -64'sd32768) begin
            sat = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic cau_pkg::t_res compute_result(input t_op op);
        logic signed [63:0] ar, ai, br, bi, re, im, den, scale;
        cau_pkg::t_res r;
        logic sat;
        ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
        re = 0; im = 0; sat = 1'b0;
        scale = 64'sd1 << cau_pkg::FRAC_BITS_DEF;
        r.dz = 1'b0;
        case (op.mode)
            cau_pkg::MODE_ADD: begin re = ar + br; im = ai + bi; end
            cau_pkg::MODE_SUB: begin re = ar - br; im = ai - bi; end
            cau_pkg::MODE_MUL: begin
                re = floor_q(ar * br - ai * bi, scale);
                im = floor_q(ai * br + ar * bi, scale);
            end
            cau_pkg::MODE_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    re = floor_q((ar * br + ai * bi) * scale, den);
                    im = floor_q((ai * br - ar * bi) * scale, den);
                end
            end
            cau_pkg::MODE_CONJ: begin re = ar; im = -ai; end
            cau_pkg::MODE_MAG:  re = $signed(int_sqrt(ar * ar + ai * ai));
            default: ;
        endcase
        r.re  = sat16(re, sat);
        r.im  = sat16(im, sat);
        r.sat = sat;
        return r;
    endfunction

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_op op;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // transaction taken this edge: log its prediction
            if (i_valid && !o_stall) begin
                op = '{i_mode, i_a_re, i_a_im, i_b_re, i_b_im};
                expected_res.push_back(compute_result(op));
                mode_seen[i_mode]++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pending_ops.size() == 0 || hold_send) begin
                    i_valid <= 1'b0;
                end else begin
                    op = pending_ops.pop_front();
                    i_valid <= 1'b1;
                    i_mode  <= op.mode;
                    i_a_re  <= op.a_re;
                    i_a_im  <= op.a_im;
                    i_b_re  <= op.b_re;
                    i_b_im  <= op.b_im;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        // some bursts are followed by no gap at all
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver stall pattern: phases of free flow, light and heavy back-pressure
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_phase <= $urandom_range(0, 2);
            case (stall_phase)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ---------------- monitor ----------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        cau_pkg::t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_res.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_res.pop_front();
                if (o_res_re != want.re) report_mismatch("res_re", o_res_re, want.re);
                if (o_res_im != want.im) report_mismatch("res_im", o_res_im, want.im);
                if (o_div_zero != want.dz) report_mismatch("div_zero", o_div_zero, want.dz);
                if (o_saturated != want.sat)
                    report_mismatch("saturated", o_saturated, want.sat);
            end
            n_checked++;
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("watchdog expired, %0d results outstanding", expected_res.size());
                $display("tb_complex_arithmetic_unit: errors");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic signed [15:0] rand_val();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'(signed'($urandom_range(0, 1024)) - 512); // near zero
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_op(input logic [2:0] m, input logic signed [15:0] ar, ai, br, bi);
        pending_ops.push_back('{m, ar, ai, br, bi});
    endtask

    initial begin
        t_op op;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_mode  = cau_pkg::MODE_ADD;
        i_a_re  = '0; i_a_im = '0; i_b_re = '0; i_b_im = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every mode, divide by zero, saturation, unused codes
        add_op(cau_pkg::MODE_ADD,  16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        add_op(cau_pkg::MODE_ADD,  16'sh0100, -16'sh0100, 16'sh0080, 16'sh0040);
        add_op(cau_pkg::MODE_SUB,  16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        add_op(cau_pkg::MODE_SUB,  16'sh0000, 16'sh0000, 16'sh8000, 16'sh0001);
        add_op(cau_pkg::MODE_MUL,  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        add_op(cau_pkg::MODE_MUL,  16'sh0100, 16'sh0000, -16'sh0001, 16'sh0000);
        add_op(cau_pkg::MODE_MUL,  16'sh0180, 16'sh0040, -16'sh0123, 16'sh0077);
        add_op(cau_pkg::MODE_DIV,  16'sh1234, 16'sh4321, 16'sh0000, 16'sh0000);
        add_op(cau_pkg::MODE_DIV,  16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        add_op(cau_pkg::MODE_DIV,  16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
        add_op(cau_pkg::MODE_DIV,  -16'sh0100, 16'sh0000, 16'sh0300, 16'sh0000);
        add_op(cau_pkg::MODE_DIV,  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        add_op(cau_pkg::MODE_DIV,  16'sh0001, 16'sh0000, 16'sh7fff, 16'sh7fff);
        add_op(cau_pkg::MODE_CONJ, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
        add_op(cau_pkg::MODE_CONJ, 16'sh7fff, 16'sh7fff, 16'sh1111, 16'sh2222);
        add_op(cau_pkg::MODE_MAG,  16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
        add_op(cau_pkg::MODE_MAG,  16'sh0300, 16'sh0400, 16'sh0000, 16'sh0000);
        add_op(cau_pkg::MODE_MAG,  16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff);
        add_op(3'd6,               16'sh1234, 16'sh5678, 16'sh0100, 16'sh0100);
        add_op(3'd7,               16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000);

        // let the directed set drain completely before the random stream
        wait (pending_ops.size() == 0);
        hold_send = 1'b1;
        wait (expected_res.size() == 0 && !i_valid);
        hold_send = 1'b0;

        for (int k = 0; k < N_RANDOM; k++) begin
            op.mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
            op.a_re = rand_val();
            op.a_im = rand_val();
            op.b_re = rand_val();
            op.b_im = rand_val();
            if (op.mode == cau_pkg::MODE_DIV && $urandom_range(0, 9) == 0) begin
                op.b_re = '0;
                op.b_im = '0;
            end
            pending_ops.push_back(op);
        end

        wait (pending_ops.size() == 0);
        @(posedge i_clk);
        wait (expected_res.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("checked %0d results; mode counts add %0d sub %0d mul %0d div %0d",
                 n_checked, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
        $display("conj %0d mag %0d unused %0d", mode_seen[4], mode_seen[5],
                 mode_seen[6] + mode_seen[7]);
        if (n_errors == 0 && expected_res.size() == 0) begin
            $display("tb_complex_arithmetic_unit: clean");
        end else begin
            $display("tb_complex_arithmetic_unit: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
